### hdl/ahp_pkg.sv
// Shared types, constants and helpers for the autoscaled history plotter.
`default_nettype none

package ahp_pkg;

    // Sizing
    localparam int HISTORY_DEPTH = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_COLUMNS   = 64;

    localparam int VAL_W  = 16;
    localparam int RING_W = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS : VAL_W;
    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int SCAN_W = $clog2(HISTORY_DEPTH + 1);
    localparam int NCOLS  = (HISTORY_DEPTH < MAX_COLUMNS) ? HISTORY_DEPTH : MAX_COLUMNS;
    localparam int COL_W  = $clog2(NCOLS);

    // Plot geometry
    localparam int PLOT_TOP  = 16;
    localparam int PLOT_ROWS = 48;
    localparam int FLAT_ROW  = 64;
    localparam int X_RIGHT   = 127;
    localparam int XY_W      = 7;
    localparam int MID_W     = 8;

    // Row divider: quotient never exceeds PLOT_ROWS
    localparam int NUM_W     = VAL_W + $clog2(PLOT_ROWS);
    localparam int QUOT_BITS = $clog2(PLOT_ROWS + 1);
    localparam int DCNT_W    = $clog2(QUOT_BITS);

    // Register reset values
    localparam logic [VAL_W-1:0] CEIL_RESET  = 16'd2200;
    localparam logic [VAL_W-1:0] FLOOR_RESET = 16'd0;
    localparam logic [VAL_W-1:0] CAP_RESET   = 16'd15;
    localparam logic [VAL_W-1:0] SPAN_RESET  = 16'd20;

    // APB
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    typedef enum logic [1:0] {
        REG_UPPER_CEILING = 2'd0,
        REG_LOWER_FLOOR   = 2'd1,
        REG_LOWER_CAP     = 2'd2,
        REG_MIN_SPAN      = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WIDEN,
        ST_CLAMP,
        ST_PREV_RD,
        ST_LOAD,
        ST_DIV,
        ST_COL_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [XY_W-1:0]         col_x;
        logic [XY_W-1:0]         col_y;
        logic [XY_W-1:0]         mid_x;
        logic signed [MID_W-1:0] mid_y;
        logic [VAL_W-1:0]        scale_low;
        logic [VAL_W-1:0]        scale_high;
        logic                    last_column;
    } result_t;

    typedef struct packed {
        logic [VAL_W-1:0] upper_ceiling;
        logic [VAL_W-1:0] lower_floor;
        logic [VAL_W-1:0] lower_cap;
        logic [VAL_W-1:0] min_span;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Ring pointer step back with wrap
    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        ring_dec = (a == '0) ? AW'(HISTORY_DEPTH - 1) : a - AW'(1);
    endfunction

    // Ring pointer step forward with wrap
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        ring_inc = (a == AW'(HISTORY_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

endpackage

`default_nettype wire

### hdl/autoscaled_history_plotter.sv
// Autoscaled history plotter: sample ring, scale search and per-column plot output.
// Record transaction: written into the ring when accepted, no result.
// Render transaction: a scan over every ring entry, widen and clamp steps, a divide
//   to prime the midpoint row, then per column a ring read, divider load, divide and emit;
//   the emit waits while the result side stalls.
// One transaction at a time; the result register holds the last column while idle.
// Reset: ring reads as empty (per-entry valid bits cleared), write pointer zero,
//   registers at their defaults; ready right after reset.
`default_nettype none

module autoscaled_history_plotter
    import ahp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire item_t              item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output result_t                 result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [AW-1:0]            wp_reg;
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [SCAN_W-1:0]        scan_cnt_reg;
    logic [COL_W-1:0]         col_cnt_reg;
    logic [AW-1:0]            col_addr_reg;
    logic                     first_reg;
    logic                     any_reg;
    logic                     rd_valid_reg;
    logic [VAL_W-1:0]         lo_reg;
    logic [VAL_W:0]           hi_reg;
    logic [XY_W-1:0]          y_reg;
    logic [XY_W-1:0]          yprev_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic                 accept;
    logic                 rec;
    logic                 ren;
    logic                 out_free;
    logic                 last_col;
    logic [AW-1:0]        raddr;
    logic                 div_start;
    logic                 emit;
    logic [RING_W-1:0]    ram_rdata;
    logic [VAL_W-1:0]     samp;
    div_stat_t            div_stat;
    logic [QUOT_BITS-1:0] quot;

    logic [VAL_W-1:0]        hi16;
    logic [VAL_W-1:0]        half_span;
    logic [VAL_W-1:0]        lo_mx;
    logic [VAL_W-1:0]        span;
    logic                    flat;
    logic [VAL_W-1:0]        off;
    logic [NUM_W-1:0]        num;
    logic [XY_W-1:0]         y_new;
    logic signed [MID_W-1:0] dlt;
    logic signed [MID_W-1:0] hlf;
    logic signed [MID_W-1:0] mid_y;

    assign accept   = item_valid && item_ready;
    assign rec      = accept && (item.kind == KIND_RECORD);
    assign ren      = accept && (item.kind == KIND_RENDER);
    assign out_free = !result_valid_reg || result_ready;
    assign last_col = col_cnt_reg == COL_W'(NCOLS - 1);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    ahp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ahp_ram #(
        .WIDTH (RING_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (rec),
        .waddr (wp_reg),
        .wdata (RING_W'(item.sample_value)),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    ahp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (span),
        .stat  (div_stat),
        .quot  (quot)
    );

    // Entries never written read as empty
    assign samp = rd_valid_reg ? VAL_W'(ram_rdata) : '0;

    // Scale arithmetic
    assign hi16      = hi_reg[VAL_W-1:0];
    assign half_span = cfg.min_span >> 1;
    assign lo_mx     = (lo_reg < cfg.lower_floor) ? cfg.lower_floor : lo_reg;
    assign span      = hi16 - lo_reg;
    assign flat      = hi16 <= lo_reg;

    // Row of one sample: offset clamped to the span, 48*(span-off)/span
    always_comb
    begin
        off = (samp > lo_reg) ? samp - lo_reg : '0;
        if (off > span)
        begin
            off = span;
        end
        num = NUM_W'(span - off) * NUM_W'(PLOT_ROWS);
    end

    assign y_new = flat ? XY_W'(FLAT_ROW) : XY_W'(PLOT_TOP) + XY_W'(quot);

    // Midpoint row, half difference truncated toward zero
    always_comb
    begin
        dlt   = $signed({1'b0, yprev_reg}) - $signed({1'b0, y_reg});
        hlf   = (dlt + $signed({{(MID_W-1){1'b0}}, dlt[MID_W-1]})) >>> 1;
        mid_y = $signed({1'b0, y_reg}) - hlf;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ren)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == SCAN_W'(HISTORY_DEPTH))
                begin
                    state_next = ST_WIDEN;
                end
            end
            ST_WIDEN:   state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_PREV_RD;
            ST_PREV_RD: state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = first_reg ? ST_COL_RD : ST_EMIT;
                end
            end
            ST_COL_RD:  state_next = ST_LOAD;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_col ? ST_IDLE : ST_COL_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        item_ready = 1'b0;
        raddr      = '0;
        div_start  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:    item_ready = 1'b1;
            ST_SCAN:
            begin
                if (scan_cnt_reg < SCAN_W'(HISTORY_DEPTH))
                begin
                    raddr = scan_cnt_reg[AW-1:0];
                end
            end
            ST_PREV_RD: raddr = ring_dec(ring_dec(wp_reg));
            ST_LOAD:    div_start = 1'b1;
            ST_COL_RD:  raddr = col_addr_reg;
            ST_EMIT:    emit = out_free;
            default:    item_ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wp_reg           <= '0;
            valid_reg        <= '0;
            scan_cnt_reg     <= '0;
            col_cnt_reg      <= '0;
            first_reg        <= 1'b0;
            any_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (rec)
            begin
                valid_reg[wp_reg] <= 1'b1;
                wp_reg            <= ring_inc(wp_reg);
            end

            if (ren)
            begin
                scan_cnt_reg <= '0;
                any_reg      <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg != '0 && samp != '0)
                begin
                    any_reg <= 1'b1;
                end
            end

            if (state_reg == ST_CLAMP)
            begin
                first_reg <= 1'b1;
            end
            else if (state_reg == ST_DIV && div_stat.done && first_reg)
            begin
                first_reg   <= 1'b0;
                col_cnt_reg <= '0;
            end
            else if (emit)
            begin
                col_cnt_reg <= col_cnt_reg + COL_W'(1);
            end

            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[raddr];

        if (ren)
        begin
            hi_reg <= '0;
        end
        else if (state_reg == ST_SCAN && scan_cnt_reg != '0 && samp != '0)
        begin
            // min and max over nonzero samples
            if (samp > hi16)
            begin
                hi_reg <= (VAL_W+1)'(samp);
            end
            if (!any_reg || samp < lo_reg)
            begin
                lo_reg <= samp;
            end
        end

        // Widen a narrow range; an empty ring takes the cap as its bottom
        if (state_reg == ST_WIDEN)
        begin
            if (!any_reg)
            begin
                lo_reg <= cfg.lower_cap;
            end
            else if (hi16 - lo_reg < cfg.min_span)
            begin
                lo_reg <= (lo_reg > half_span) ? lo_reg - half_span : '0;
                hi_reg <= (VAL_W+1)'(hi16) + (VAL_W+1)'(half_span);
            end
        end

        // Clamp to ceiling, floor and cap
        if (state_reg == ST_CLAMP)
        begin
            if (hi_reg > (VAL_W+1)'(cfg.upper_ceiling))
            begin
                hi_reg <= (VAL_W+1)'(cfg.upper_ceiling);
            end
            lo_reg <= (lo_mx > cfg.lower_cap) ? cfg.lower_cap : lo_mx;
        end

        if (state_reg == ST_DIV && div_stat.done)
        begin
            y_reg <= y_new;
            if (first_reg)
            begin
                yprev_reg    <= y_new;
                col_addr_reg <= ring_dec(wp_reg);
            end
        end

        if (emit)
        begin
            result_reg.col_x       <= XY_W'(X_RIGHT) - XY_W'({col_cnt_reg, 1'b0});
            result_reg.col_y       <= y_reg;
            result_reg.mid_x       <= XY_W'(X_RIGHT - 1) - XY_W'({col_cnt_reg, 1'b0});
            result_reg.mid_y       <= mid_y;
            result_reg.scale_low   <= lo_reg;
            result_reg.scale_high  <= hi16;
            result_reg.last_column <= last_col;
            yprev_reg              <= y_reg;
            col_addr_reg           <= ring_dec(col_addr_reg);
        end
    end

    // Divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside divide state");

    // A recorded sample moves the write pointer
    a_wp_moves: assert property (@(posedge clk) disable iff (!rst_n)
        rec |=> wp_reg != $past(wp_reg))
        else $error("write pointer did not advance");

    // Emitted main row stays inside the plot band
    a_row_band: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (result_reg.col_y >= XY_W'(PLOT_TOP)) && (result_reg.col_y <= XY_W'(FLAT_ROW)))
        else $error("main row outside plot band");

endmodule

`default_nettype wire

### hdl/ahp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ahp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/ahp_cfg.sv
// APB register file for the plot scale limits.
`default_nettype none

module ahp_cfg
    import ahp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_ceiling <= CEIL_RESET;
            cfg_reg.lower_floor   <= FLOOR_RESET;
            cfg_reg.lower_cap     <= CAP_RESET;
            cfg_reg.min_span      <= SPAN_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_UPPER_CEILING: cfg_reg.upper_ceiling <= pwdata[VAL_W-1:0];
                REG_LOWER_FLOOR:   cfg_reg.lower_floor   <= pwdata[VAL_W-1:0];
                REG_LOWER_CAP:     cfg_reg.lower_cap     <= pwdata[VAL_W-1:0];
                REG_MIN_SPAN:      cfg_reg.min_span      <= pwdata[VAL_W-1:0];
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_UPPER_CEILING: prdata = PDATA_W'(cfg_reg.upper_ceiling);
            REG_LOWER_FLOOR:   prdata = PDATA_W'(cfg_reg.lower_floor);
            REG_LOWER_CAP:     prdata = PDATA_W'(cfg_reg.lower_cap);
            REG_MIN_SPAN:      prdata = PDATA_W'(cfg_reg.min_span);
        endcase
    end

endmodule

`default_nettype wire

### hdl/ahp_div.sv
// Restoring divider, one quotient bit per cycle, for the plot row.
`default_nettype none

module ahp_div
    import ahp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_W-1:0]     num,
    input  wire logic [VAL_W-1:0]     den,
    output div_stat_t                 stat,
    output logic      [QUOT_BITS-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DCNT_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     dsh_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic                 ge;

    assign ge        = rem_reg >= dsh_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(QUOT_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare against the shifted divisor, subtract on a hit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsh_reg  <= NUM_W'(den) << (QUOT_BITS - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUOT_BITS-2:0], ge};
        end
    end

endmodule

`default_nettype wire

### bench/autoscaled_history_plotter_tb.sv
// Testbench for the autoscaled history plotter: record/render traffic checked per plot column.
module autoscaled_history_plotter_tb;
    import ahp_pkg::*;

    localparam int unsigned EMPTY_LOW    = 999999;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          LONG_HOLD    = 3000;
    localparam int          MAX_REPORTS  = 20;
    localparam longint      TIMEOUT      = 64'd10_000_000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow of the sample ring and scale registers
    logic [VAL_W-1:0] history_copy [HISTORY_DEPTH] = '{default: '0};
    int unsigned      history_wp = 0;
    cfg_t             scale_cfg  = '{CEIL_RESET, FLOOR_RESET, CAP_RESET, SPAN_RESET};

    item_t   history_cmds [$];
    result_t expected_pixels [$];

    int   send_idle_pct = 38;
    int   recv_idle_pct = 86;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    int   fail_count    = 0;

    autoscaled_history_plotter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Row of one sample within the scale; flat when the span is empty or inverted
    function automatic int unsigned plot_row(int unsigned v, int unsigned lo, int unsigned hi);
        int unsigned span;
        int unsigned off;
        if (hi <= lo)
            return FLAT_ROW;
        span = hi - lo;
        off  = (v > lo) ? v - lo : 0;
        if (off > span)
            off = span;
        return PLOT_TOP + (PLOT_ROWS * (span - off)) / span;
    endfunction

    // Ring slot holding the sample recorded back+1 records ago
    function automatic int unsigned slot_back(int unsigned back);
        return (history_wp + 2 * HISTORY_DEPTH - 1 - back % HISTORY_DEPTH) % HISTORY_DEPTH;
    endfunction

    // Scale search, widening and clamping, then one pixel pair per column
    function automatic void predict_plot();
        int unsigned lo;
        int unsigned hi;
        int unsigned half;
        int unsigned v;
        int unsigned y;
        int unsigned yprev;
        int          diff;
        int          midy;
        bit          any;
        result_t     px;
        lo  = EMPTY_LOW;
        hi  = 0;
        any = 1'b0;
        foreach (history_copy[k])
        begin
            v = history_copy[k];
            if (v != 0)
            begin
                any = 1'b1;
                if (v > hi)
                    hi = v;
                if (v < lo)
                    lo = v;
            end
        end
        if (any && hi - lo < scale_cfg.min_span)
        begin
            half = scale_cfg.min_span / 2;
            lo   = (lo > half) ? lo - half : 0;
            hi   = hi + half;
        end
        if (hi > scale_cfg.upper_ceiling)
            hi = scale_cfg.upper_ceiling;
        if (lo < scale_cfg.lower_floor)
            lo = scale_cfg.lower_floor;
        if (lo > scale_cfg.lower_cap)
            lo = scale_cfg.lower_cap;

        // newest column borrows its midpoint source from column 1
        yprev = plot_row(history_copy[slot_back(1)], lo, hi);
        for (int i = 0; i < NCOLS; i++)
        begin
            y    = plot_row(history_copy[slot_back(i)], lo, hi);
            diff = (int'(yprev) - int'(y)) / 2;
            midy = int'(y) - diff;
            px.col_x       = XY_W'(X_RIGHT - 2 * i);
            px.col_y       = XY_W'(y);
            px.mid_x       = XY_W'(X_RIGHT - 1 - 2 * i);
            px.mid_y       = MID_W'(midy);
            px.scale_low   = VAL_W'(lo);
            px.scale_high  = VAL_W'(hi);
            px.last_column = (i == NCOLS - 1);
            expected_pixels.push_back(px);
            yprev = y;
        end
    endfunction

    function automatic void accept_item(item_t it);
        if (it.kind == KIND_RECORD)
        begin
            history_copy[history_wp] = it.sample_value;
            history_wp = (history_wp + 1) % HISTORY_DEPTH;
        end
        else
            predict_plot();
    endfunction

    function automatic void report_field(string field, integer want, integer got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function automatic void compare_pixel(result_t want, result_t got);
        if (got.col_x !== want.col_x)
            report_field("col_x", want.col_x, got.col_x);
        if (got.col_y !== want.col_y)
            report_field("col_y", want.col_y, got.col_y);
        if (got.mid_x !== want.mid_x)
            report_field("mid_x", want.mid_x, got.mid_x);
        if (got.mid_y !== want.mid_y)
            report_field("mid_y", want.mid_y, got.mid_y);
        if (got.scale_low !== want.scale_low)
            report_field("scale_low", want.scale_low, got.scale_low);
        if (got.scale_high !== want.scale_high)
            report_field("scale_high", want.scale_high, got.scale_high);
        if (got.last_column !== want.last_column)
            report_field("last_column", want.last_column, got.last_column);
    endfunction

    // Item driver: pops pending commands, idles at random between transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                accept_item(item);
            if (!item_valid || item_ready)
            begin
                if (history_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item       <= history_cmds.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result side ready: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= LONG_HOLD;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected pixel, expected none, got %p", $time, result);
            end
            else
                compare_pixel(expected_pixels.pop_front(), result);
        end
    end

    // APB write: setup, then access until pready
    task automatic write_reg(reg_idx_t idx, logic [VAL_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_UPPER_CEILING: scale_cfg.upper_ceiling = value;
            REG_LOWER_FLOOR:   scale_cfg.lower_floor   = value;
            REG_LOWER_CAP:     scale_cfg.lower_cap     = value;
            REG_MIN_SPAN:      scale_cfg.min_span      = value;
            default:           ;
        endcase
    endtask

    task automatic set_scale(logic [VAL_W-1:0] ceiling, logic [VAL_W-1:0] floor_v,
                             logic [VAL_W-1:0] cap, logic [VAL_W-1:0] span);
        write_reg(REG_UPPER_CEILING, ceiling);
        write_reg(REG_LOWER_FLOOR, floor_v);
        write_reg(REG_LOWER_CAP, cap);
        write_reg(REG_MIN_SPAN, span);
    endtask

    // Sender pause: everything accepted, every pixel back, block drained;
    // checked on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (history_cmds.size() != 0 || item_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_item(logic kind, logic [VAL_W-1:0] value);
        item_t it;
        it.kind         = kind;
        it.sample_value = value;
        history_cmds.push_back(it);
    endfunction

    // Random records/renders; samples mix empty, full-range and clustered values
    function automatic void queue_random(int count, int render_pct, int unsigned base,
                                         int unsigned spread);
        int unsigned pick;
        int unsigned near;
        logic        kind;
        repeat (count)
        begin
            kind = ($urandom_range(0, 99) < render_pct) ? KIND_RENDER : KIND_RECORD;
            pick = $urandom_range(0, 9);
            near = base + $urandom_range(0, spread);
            if (near > 16'hFFFF)
                near = 16'hFFFF;
            if (pick < 2)
                queue_item(kind, '0);
            else if (pick < 5)
                queue_item(kind, VAL_W'($urandom));
            else
                queue_item(kind, VAL_W'(near));
        end
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty ring, widening at zero, empty slots, ceiling clamp
        queue_item(KIND_RENDER, 16'h0000);
        queue_item(KIND_RECORD, 16'h0001);
        queue_item(KIND_RENDER, 16'hFFFF);
        queue_item(KIND_RECORD, 16'hFFFF);
        queue_item(KIND_RECORD, 16'h0000);
        queue_item(KIND_RECORD, 16'h5555);
        queue_item(KIND_RECORD, 16'hAAAA);
        queue_item(KIND_RECORD, 16'd2195);
        queue_item(KIND_RENDER, 16'h5555);
        queue_item(KIND_RECORD, 16'd7);
        queue_item(KIND_RECORD, 16'd9);
        queue_item(KIND_RENDER, 16'hAAAA);
        wait_idle();

        // All registers at zero
        set_scale(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_random(30, 20, 0, 40);
        wait_idle();

        // All registers at full scale
        send_idle_pct <= 86;
        recv_idle_pct <= 38;
        set_scale(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(30, 20, 65000, 535);
        wait_idle();

        // Random registers around a random cluster
        set_scale(VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
        queue_random(40, 20, $urandom_range(0, 65000), 300);
        wait_idle();

        // Realistic scale, no idling, one long result-side hold-off
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        set_scale(16'd3000, 16'd300, 16'd800, 16'd100);
        queue_item(KIND_RENDER, VAL_W'($urandom));
        queue_random(100, 20, 350, 2000);
        hold_req <= 1'b1;
        wait_idle();

        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #TIMEOUT;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### autoscaled_history_plotter.f
hdl/ahp_pkg.sv
hdl/ahp_ram.sv
hdl/ahp_cfg.sv
hdl/ahp_div.sv
hdl/autoscaled_history_plotter.sv
bench/autoscaled_history_plotter_tb.sv
